/* hdl/inba_pkg.sv */
// Shared types and constants for the interrupt number bitmap allocator.
`default_nettype none

package inba_pkg;

  localparam int NUM_IRQS   = 256;
  localparam int IRQ_W      = 10;
  localparam int WORD_SHIFT = 6;
  localparam int WORD_W     = 1 << WORD_SHIFT;
  localparam int BIT_MASK   = WORD_W - 1;
  localparam int NUM_WORDS  = (NUM_IRQS + BIT_MASK) / WORD_W;
  localparam int PAD_BITS   = NUM_WORDS * WORD_W;
  localparam int IDX_W      = $clog2(NUM_IRQS);

  typedef enum logic [1:0] {
    FN_ALLOC = 2'd0,
    FN_FREE  = 2'd1,
    FN_TEST  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_RANGE     = 2'd1,
    ST_NONE_FREE = 2'd2,
    ST_RESERVED  = 2'd3
  } status_t;

  typedef struct packed {
    func_t            func;
    logic             use_any;
    logic [IRQ_W-1:0] irq_req;
    logic             keep_reserved;
  } cmd_t;

  typedef struct packed {
    status_t          status;
    logic [IRQ_W-1:0] irq_granted;
    logic             is_allocated;
  } rsp_t;

endpackage

`default_nettype wire

/* hdl/inba_core.sv */
// Allocation and reservation bitmaps with lowest-free search and single-bit update.
`default_nettype none

module inba_core import inba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic fire,
  input  wire cmd_t cmd,
  output rsp_t      rsp
);

  logic [NUM_IRQS-1:0]  alloc_r, alloc_nxt;
  logic [NUM_IRQS-1:0]  rsvd_r, rsvd_nxt;
  logic [PAD_BITS-1:0]  avail_pad;
  logic [NUM_WORDS-1:0] word_free, word_oh;
  logic [WORD_W-1:0]    sel_word, bit_oh;
  logic [IRQ_W-1:0]     word_base;
  logic [WORD_SHIFT-1:0] bit_idx;
  logic [IRQ_W-1:0]     search_num;
  logic                 found;
  logic                 in_range;
  logic [IRQ_W-1:0]     tgt;
  logic [IDX_W-1:0]     tix;
  logic                 old_bit, res_bit;
  logic                 is_search;
  status_t              status;
  logic                 alloc_out;

  // lowest-free search: first word with a free bit, then first free bit in it
  always_comb begin
    avail_pad = PAD_BITS'(~alloc_r);
    for (int w = 0; w < NUM_WORDS; w++) begin
      word_free[w] = |avail_pad[w*WORD_W +: WORD_W];
    end
    word_oh   = word_free & (~word_free + NUM_WORDS'(1));
    sel_word  = '0;
    word_base = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (word_oh[w]) begin
        sel_word  = sel_word | avail_pad[w*WORD_W +: WORD_W];
        word_base = word_base | IRQ_W'(w * WORD_W);
      end
    end
    bit_oh  = sel_word & (~sel_word + WORD_W'(1));
    bit_idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (bit_oh[i]) begin
        bit_idx = bit_idx | WORD_SHIFT'(i);
      end
    end
    search_num = word_base | IRQ_W'(bit_idx);
    found      = |word_free;
  end

  // resolve the target number, the status, the next bitmaps and the response
  always_comb begin
    is_search = (cmd.func == FN_ALLOC) && cmd.use_any;
    in_range  = {1'b0, cmd.irq_req} < (IRQ_W+1)'(NUM_IRQS);
    tgt       = is_search ? search_num : cmd.irq_req;
    tix       = tgt[IDX_W-1:0];
    old_bit   = alloc_r[tix];
    res_bit   = rsvd_r[tix];

    if (is_search && !found) begin
      status = ST_NONE_FREE;
    end else if (!is_search && !in_range) begin
      status = ST_RANGE;
    end else if (cmd.func == FN_FREE && res_bit) begin
      status = ST_RESERVED;
    end else begin
      status = ST_DONE;
    end

    case (cmd.func)
      FN_ALLOC: alloc_out = 1'b1;
      FN_FREE:  alloc_out = res_bit ? old_bit : 1'b0;
      default:  alloc_out = old_bit;
    endcase

    alloc_nxt = alloc_r;
    rsvd_nxt  = rsvd_r;
    if (fire && status == ST_DONE) begin
      case (cmd.func)
        FN_ALLOC: begin
          alloc_nxt[tix] = 1'b1;
          if (cmd.keep_reserved) begin
            rsvd_nxt[tix] = 1'b1;
          end
        end
        FN_FREE:  alloc_nxt[tix] = 1'b0;
        default:  alloc_nxt = alloc_r;
      endcase
    end

    rsp.status = status;
    if (status == ST_RANGE || status == ST_NONE_FREE) begin
      rsp.irq_granted  = '0;
      rsp.is_allocated = 1'b0;
    end else begin
      rsp.irq_granted  = tgt;
      rsp.is_allocated = alloc_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
      rsvd_r  <= '0;
    end else begin
      alloc_r <= alloc_nxt;
      rsvd_r  <= rsvd_nxt;
    end
  end

  // reservation bits never clear
  a_rsvd_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> ((rsvd_r & $past(rsvd_r)) == $past(rsvd_r)))
    else $error("reservation bit cleared");

  // a reserved number stays allocated
  a_rsvd_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (rsvd_r & ~alloc_r) == '0)
    else $error("reserved number not allocated");

  // search miss only when the map is full
  a_none_free: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && rsp.status == ST_NONE_FREE) |-> (&alloc_r))
    else $error("search miss with free numbers");

endmodule

`default_nettype wire

/* hdl/irq_number_bitmap_allocator_top.sv */
// Top level of the interrupt number bitmap allocator: input and result registers.
// Path: input register, then the core's combinational search and update, then result register.
// Throughput: one beat per cycle unless out_stall holds a full result register; the lowest-free
// priority encoder and the single-bit bitmap update work combinationally on the input register's beat.
// Reset: synchronous active-low rst_n clears both bitmaps and all valid flags;
// the block accepts beats in the first cycle after reset.
`default_nettype none

module irq_number_bitmap_allocator_top import inba_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_func,
  input  wire logic             in_use_any,
  input  wire logic [IRQ_W-1:0] in_irq_req,
  input  wire logic             in_keep_reserved,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            out_status,
  output logic [IRQ_W-1:0]      out_irq_granted,
  output logic                  out_is_allocated
);

  logic s1_valid_r, s1_valid_nxt;
  cmd_t s1_cmd_r;
  logic out_valid_r, out_valid_nxt;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic s1_adv;
  logic in_take;

  always_comb begin
    s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall = s1_valid_r && !s1_adv;
    in_take  = in_valid && !in_stall;

    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  inba_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_adv),
    .cmd   (s1_cmd_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r.func          <= func_t'(in_func);
      s1_cmd_r.use_any       <= in_use_any;
      s1_cmd_r.irq_req       <= in_irq_req;
      s1_cmd_r.keep_reserved <= in_keep_reserved;
    end
    if (s1_adv) begin
      out_rsp_r <= rsp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_rsp_r.status;
  assign out_irq_granted  = out_rsp_r.irq_granted;
  assign out_is_allocated = out_rsp_r.is_allocated;

  // hold the input stage only while a beat sits in it
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("stall with empty input stage");

  // error results carry no number
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rsp_r.status == ST_RANGE || out_rsp_r.status == ST_NONE_FREE))
      |-> (out_rsp_r.irq_granted == '0 && !out_rsp_r.is_allocated))
    else $error("error result with number");

  // a completed allocate leaves its number allocated
  a_alloc_set: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r.func == FN_ALLOC && rsp.status == ST_DONE) |=> out_rsp_r.is_allocated)
    else $error("allocate result not allocated");

  // no result appears without an advancing input beat
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result without input beat");

endmodule

`default_nettype wire

/* sim/irq_number_bitmap_allocator_top_tb.sv */
// Testbench for irq_number_bitmap_allocator_top: queued stimulus, bitmap predictor, beat checker.
`timescale 1ns / 100ps

module irq_number_bitmap_allocator_top_tb;
  import inba_pkg::*;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [1:0]       func;
    logic             use_any;
    logic [IRQ_W-1:0] irq;
    logic             keep;
  } irq_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic in_use_any = 1'b0;
  logic [IRQ_W-1:0] in_irq_req = '0;
  logic in_keep_reserved = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [IRQ_W-1:0] out_irq_granted;
  logic out_is_allocated;

  irq_cmd_t pend_q[$];
  rsp_t grant_q[$];
  bit alloc_map [NUM_IRQS];
  bit resv_map [NUM_IRQS];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  irq_number_bitmap_allocator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_use_any       (in_use_any),
    .in_irq_req       (in_irq_req),
    .in_keep_reserved (in_keep_reserved),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_irq_granted  (out_irq_granted),
    .out_is_allocated (out_is_allocated)
  );

  function automatic rsp_t predict_grant(irq_cmd_t c);
    rsp_t r;
    int n;
    r.status = ST_DONE;
    r.irq_granted = '0;
    r.is_allocated = 1'b0;
    n = int'(c.irq);
    if (c.func == FN_ALLOC && c.use_any) begin
      n = NUM_IRQS;
      for (int i = NUM_IRQS - 1; i >= 0; i--)
        if (!alloc_map[i]) n = i;
      if (n == NUM_IRQS) r.status = ST_NONE_FREE;
    end else if (n >= NUM_IRQS) begin
      r.status = ST_RANGE;
    end
    if (r.status == ST_DONE) begin
      if (c.func == FN_ALLOC) begin
        alloc_map[n] = 1'b1;
        if (c.keep) resv_map[n] = 1'b1;
      end else if (c.func == FN_FREE) begin
        if (resv_map[n]) r.status = ST_RESERVED;
        else alloc_map[n] = 1'b0;
      end
      r.irq_granted = n[IRQ_W-1:0];
      r.is_allocated = alloc_map[n];
    end
    return r;
  endfunction

  task automatic push_cmd(logic [1:0] f, logic ua, logic [IRQ_W-1:0] n, logic kr);
    irq_cmd_t c;
    c.func = f;
    c.use_any = ua;
    c.irq = n;
    c.keep = kr;
    pend_q.push_back(c);
  endtask

  task automatic push_random();
    int pick;
    logic [1:0] f;
    logic [IRQ_W-1:0] n;
    pick = $urandom_range(99);
    if (pick < 35) f = FN_ALLOC;
    else if (pick < 65) f = FN_FREE;
    else if (pick < 95) f = FN_TEST;
    else f = FN_SPARE;
    if ($urandom_range(99) < 80) n = IRQ_W'($urandom_range(NUM_IRQS - 1));
    else n = IRQ_W'($urandom_range(1023));
    push_cmd(f, 1'($urandom_range(1)), n,
             (f == FN_ALLOC) ? ($urandom_range(15) == 0) : 1'($urandom_range(1)));
  endtask

  task automatic add_mix(int count);
    int left;
    int pick;
    int run;
    int base;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        run = $urandom_range(80, 20);
        repeat (run)
          push_cmd(FN_ALLOC, 1'b1, IRQ_W'($urandom_range(1023)), $urandom_range(15) == 0);
        left -= run;
      end else if (pick < 14) begin
        run = $urandom_range(60, 10);
        base = $urandom_range(NUM_IRQS - 1);
        for (int k = 0; k < run; k++)
          push_cmd(FN_FREE, 1'($urandom_range(1)), IRQ_W'((base + k) % NUM_IRQS),
                   1'($urandom_range(1)));
        left -= run;
      end else begin
        push_random();
        left--;
      end
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    while (pend_q.size() != 0 || grant_q.size() != 0 || in_valid) @(negedge clk);
  endtask

  always @(posedge clk) begin
    irq_cmd_t cur;
    irq_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cur.func = in_func;
        cur.use_any = in_use_any;
        cur.irq = in_irq_req;
        cur.keep = in_keep_reserved;
        grant_q.push_back(predict_grant(cur));
      end
      if (!in_valid || !in_stall) begin
        if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pend_q.pop_front();
          in_valid <= 1'b1;
          in_func <= nxt.func;
          in_use_any <= nxt.use_any;
          in_irq_req <= nxt.irq;
          in_keep_reserved <= nxt.keep;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: status %0d irq %0d alloc %0d",
                     out_status, out_irq_granted, out_is_allocated);
        end else begin
          exp_rsp = grant_q.pop_front();
          if (out_status !== exp_rsp.status || out_irq_granted !== exp_rsp.irq_granted ||
              out_is_allocated !== exp_rsp.is_allocated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status %0d irq %0d alloc %0d, got %0d %0d %0d",
                       exp_rsp.status, exp_rsp.irq_granted, exp_rsp.is_allocated,
                       out_status, out_irq_granted, out_is_allocated);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("irq_number_bitmap_allocator_top test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_cmd(FN_TEST, 1'b0, 10'd0, 1'b0);
    push_cmd(FN_TEST, 1'b1, 10'd1023, 1'b1);
    push_cmd(FN_FREE, 1'b0, 10'd5, 1'b0);
    push_cmd(FN_ALLOC, 1'b1, 10'd0, 1'b0);
    push_cmd(FN_ALLOC, 1'b1, 10'd1023, 1'b1);
    push_cmd(FN_ALLOC, 1'b0, IRQ_W'(NUM_IRQS - 1), 1'b0);
    push_cmd(FN_ALLOC, 1'b0, IRQ_W'(NUM_IRQS - 1), 1'b0);
    push_cmd(FN_ALLOC, 1'b0, 10'd1023, 1'b1);
    push_cmd(FN_ALLOC, 1'b0, IRQ_W'(NUM_IRQS), 1'b0);
    push_cmd(FN_FREE, 1'b1, 10'd1, 1'b1);
    push_cmd(FN_ALLOC, 1'b0, 10'd1, 1'b0);
    push_cmd(FN_FREE, 1'b0, 10'd1, 1'b0);
    push_cmd(FN_FREE, 1'b0, 10'd0, 1'b0);
    push_cmd(FN_TEST, 1'b0, 10'd0, 1'b0);
    push_cmd(FN_SPARE, 1'b1, IRQ_W'(NUM_IRQS - 1), 1'b1);
    push_cmd(FN_SPARE, 1'b0, 10'd1023, 1'b0);
    push_cmd(FN_FREE, 1'b0, 10'd1023, 1'b0);
    push_cmd(FN_FREE, 1'b0, IRQ_W'(NUM_IRQS - 1), 1'b0);
    push_cmd(FN_ALLOC, 1'b0, 10'd0, 1'b1);
    push_cmd(FN_FREE, 1'b0, 10'd0, 1'b0);
    push_cmd(FN_TEST, 1'b0, 10'd682, 1'b0);
    push_cmd(FN_TEST, 1'b0, 10'd341, 1'b1);
    wait_drain();

    send_idle_pct = 71;
    repeat (NUM_IRQS + 12) push_cmd(FN_ALLOC, 1'b1, IRQ_W'($urandom_range(1023)), 1'b0);
    push_cmd(FN_TEST, 1'b0, IRQ_W'(NUM_IRQS - 1), 1'b0);
    for (int k = 0; k < 64; k++) push_cmd(FN_FREE, 1'b0, IRQ_W'(k), 1'b0);
    wait_drain();

    send_idle_pct = 0;
    hold_left = LONG_HOLD;
    add_mix(400);
    wait_drain();

    send_idle_pct = 71;
    add_mix(400);
    wait_drain();

    send_idle_pct = 0;
    recv_stall_pct = 71;
    add_mix(400);
    wait_drain();

    send_idle_pct = 10;
    recv_stall_pct = 10;
    add_mix(400);
    wait_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("irq_number_bitmap_allocator_top test passed");
    end else begin
      $display("irq_number_bitmap_allocator_top test failed");
    end
    $finish;
  end

endmodule
